// ----- design/radix_fraction_converter_top_macros.svh -----
// Assertion macros for the radix fraction converter.
// Used by the controller; no other dependencies.
`ifndef RADIX_FRACTION_CONVERTER_TOP_MACROS_SVH
`define RADIX_FRACTION_CONVERTER_TOP_MACROS_SVH
`define RFC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfc check failed");
`define RFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfc check failed");
`endif

// ----- design/rfc_pkg.sv -----
// Shared types and constants for the radix fraction converter.
// No dependencies.
package rfc_pkg;
    localparam int unsigned VAL_W   = 48;
    localparam int unsigned BASE_W  = 5;
    localparam int unsigned DIG_W   = 4;
    localparam int unsigned BUF_DEPTH = 48;
    localparam int unsigned BUF_AW  = 6;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_UPPA  = 8'd65;
    localparam logic [7:0] CH_LOWA  = 8'd97;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_HEXO  = 8'd55;
    localparam logic [0:0] REG_SRC  = 1'b0;
    localparam logic [0:0] REG_DST  = 1'b1;

    typedef enum logic [1:0] {
        OP_INT  = 2'b00,
        OP_FRAC = 2'b01,
        OP_IDIV = 2'b10,
        OP_FDIV = 2'b11
    } dp_op_t;

    typedef struct packed {
        logic   clear;
        logic   start;
        dp_op_t op;
        logic   [DIG_W-1:0] digit;
        logic   clr_rem;
    } dp_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              int_zero;
        logic              rem_zero;
        logic              den_zero;
        logic [DIG_W-1:0]  quot;
    } dp_sts_t;

    function automatic logic [7:0] to_ascii(input logic [DIG_W-1:0] d);
        logic [7:0] r;
        r = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_HEXO + {4'd0, d});
        return r;
    endfunction
endpackage

// ----- design/rfc_datapath.sv -----
// Datapath: 48-bit accumulators, a multiplier by the base and a
// restoring divider shared by the integer and fraction digit passes. Uses rfc_pkg.
module rfc_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [rfc_pkg::BASE_W-1:0] src_base,
    input  logic [rfc_pkg::BASE_W-1:0] dst_base,
    input  rfc_pkg::dp_cmd_t        cmd,
    output rfc_pkg::dp_sts_t        sts
);
    import rfc_pkg::*;

    logic [VAL_W-1:0] int_reg, int_next;
    logic [VAL_W-1:0] num_reg, num_next;
    logic [VAL_W-1:0] den_reg, den_next;
    logic [VAL_W:0]   rem_reg, rem_next;
    logic [DIG_W-1:0] quo_reg, quo_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    dp_op_t           op_reg, op_next;

    logic [VAL_W+3:0] trial;
    logic [VAL_W+4:0] t_prod;
    logic [VAL_W:0]   rshift;
    logic [VAL_W:0]   rsub;
    logic [VAL_W-1:0] divisor;
    logic [VAL_W-1:0] mul_a;

    always_comb begin
        int_next  = int_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        trial = '0; t_prod = '0; rshift = '0; rsub = '0;
        divisor = {{(VAL_W-BASE_W){1'b0}}, dst_base};
        mul_a = '0;
        if (cmd.clear) begin
            int_next = '0; num_next = '0; den_next = {{(VAL_W-1){1'b0}}, 1'b1};
            busy_next = 1'b0;
        end else if (cmd.start) begin
            op_next = cmd.op;
            case (cmd.op)
                OP_INT: begin
                    mul_a = int_reg;
                    t_prod = {5'd0, mul_a} * {{(VAL_W){1'b0}}, src_base};
                    int_next = t_prod[VAL_W-1:0] + {{(VAL_W-DIG_W){1'b0}}, cmd.digit};
                end
                OP_FRAC: begin
                    t_prod = {5'd0, num_reg} * {{(VAL_W){1'b0}}, src_base};
                    num_next = t_prod[VAL_W-1:0] + {{(VAL_W-DIG_W){1'b0}}, cmd.digit};
                    t_prod = {5'd0, den_reg} * {{(VAL_W){1'b0}}, src_base};
                    den_next = t_prod[VAL_W-1:0];
                end
                OP_IDIV: begin
                    rem_next = '0; quo_next = '0;
                    cnt_next = 6'(VAL_W); busy_next = 1'b1;
                end
                OP_FDIV: begin
                    t_prod = {5'd0, num_reg} * {{(VAL_W){1'b0}}, dst_base};
                    rem_next = '0; quo_next = '0;
                    trial = t_prod[VAL_W+3:0];
                    int_next = trial[VAL_W-1:0];
                    quo_next = trial[VAL_W+3:VAL_W];
                    cnt_next = 6'(VAL_W+DIG_W); busy_next = 1'b1;
                end
                default: ;
            endcase
        end else if (busy_reg) begin
            // one quotient bit per cycle; IDIV shifts int, FDIV shifts {quo,int}
            if (op_reg == OP_IDIV) begin
                rshift = {rem_reg[VAL_W-1:0], int_reg[VAL_W-1]};
                rsub = rshift - {1'b0, divisor};
                int_next = {int_reg[VAL_W-2:0], ~rsub[VAL_W]};
                rem_next = rsub[VAL_W] ? rshift : rsub;
            end else begin
                rshift = {rem_reg[VAL_W-1:0], quo_reg[DIG_W-1]};
                rsub = rshift - {1'b0, den_reg};
                quo_next = {quo_reg[DIG_W-2:0], int_reg[VAL_W-1]};
                int_next = {int_reg[VAL_W-2:0], ~rsub[VAL_W]};
                rem_next = rsub[VAL_W] ? rshift : rsub;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                if (op_reg == OP_FDIV) begin
                    num_next = rem_next[VAL_W-1:0];
                    quo_next = int_next[DIG_W-1:0];
                    int_next = '0;
                end else begin
                    quo_next = rem_next[DIG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            int_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= {{(VAL_W-1){1'b0}}, 1'b1};
        end else begin
            busy_reg <= busy_next;
            int_reg  <= int_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.int_zero = (int_reg == '0);
    assign sts.rem_zero = (num_reg == '0);
    assign sts.den_zero = (den_reg == '0);
    assign sts.quot     = quo_reg;
endmodule

// ----- design/rfc_ctrl.sv -----
// Controller: takes characters, checks them, sequences accumulation and the
// digit passes, and drives the output register. Uses rfc_pkg and the macro header.
`include "radix_fraction_converter_top_macros.svh"
module rfc_ctrl #(
    parameter int unsigned MAX_CHARS       = 12,
    parameter int unsigned MAX_FRAC_DIGITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [rfc_pkg::BASE_W-1:0] src_base,
    input  logic [rfc_pkg::BASE_W-1:0] dst_base,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_char,
    input  logic                       s_last,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_char,
    output logic                       m_bad,
    output logic                       m_last,
    output rfc_pkg::dp_cmd_t           cmd,
    input  rfc_pkg::dp_sts_t           sts
);
    import rfc_pkg::*;

    typedef enum logic [8:0] {
        ST_IN    = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_ACC   = 9'b000000100,
        ST_IDIV  = 9'b000001000,
        ST_IWAIT = 9'b000010000,
        ST_IOUT  = 9'b000100000,
        ST_DOT   = 9'b001000000,
        ST_FDIV  = 9'b010000000,
        ST_FWAIT = 9'b100000000
    } state_t;

    state_t           st_reg, st_next;
    logic [3:0]       cc_reg, cc_next;
    logic [1:0]       dc_reg, dc_next;
    logic [3:0]       dp_reg, dp_next;
    logic             err_reg, err_next;
    logic [3:0]       ix_reg, ix_next;
    logic [BUF_AW-1:0] nd_reg, nd_next;
    logic [4:0]       fc_reg, fc_next;
    logic             ov_reg, ov_next;
    logic [7:0]       mc_reg, mc_next;
    logic             mb_reg, mb_next, ml_reg, ml_next;
    logic [DIG_W-1:0] dbuf [BUF_DEPTH];
    logic [DIG_W-1:0] ibuf [16];
    logic             ib_we;
    logic [3:0]       ib_wa;
    logic [DIG_W-1:0] ib_wd;
    logic             db_we;
    logic [BUF_AW-1:0] db_wa, db_ra;
    logic [DIG_W-1:0] db_rd_reg;
    logic [DIG_W-1:0] ib_rd;
    logic [DIG_W-1:0] dval;
    logic             isdig, isdot;
    logic             bad_chk;
    logic             out_free;

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (st_reg == ST_IN) && out_free;
    assign ib_rd    = ibuf[ix_reg];

    always_comb begin
        isdig = 1'b1; isdot = 1'b0; dval = '0;
        if (s_char >= CH_ZERO && s_char < CH_ZERO + 8'd10) dval = 4'(s_char - CH_ZERO);
        else if (s_char >= CH_UPPA && s_char < CH_UPPA + 8'd6) dval = 4'(s_char - CH_HEXO);
        else if (s_char >= CH_LOWA && s_char < CH_LOWA + 8'd6)
            dval = 4'(s_char - CH_LOWA + 8'd10);
        else begin
            isdig = 1'b0;
            isdot = (s_char == CH_DOT);
        end
    end

    always_comb begin
        bad_chk = err_reg || (cc_reg > 4'(MAX_CHARS));
        if (src_base < 5'd2 || src_base > 5'd16 || dst_base < 5'd2 || dst_base > 5'd16)
            bad_chk = 1'b1;
        if (dc_reg > 2'd1) bad_chk = 1'b1;
        if (dc_reg == 2'd1 && (dp_reg == 4'd0 || dp_reg + 4'd1 == cc_reg)) bad_chk = 1'b1;
    end

    always_comb begin
        st_next = st_reg; cc_next = cc_reg; dc_next = dc_reg; dp_next = dp_reg;
        err_next = err_reg; ix_next = ix_reg; nd_next = nd_reg; fc_next = fc_reg;
        ov_next = ov_reg; mc_next = mc_reg; mb_next = mb_reg; ml_next = ml_reg;
        ib_we = 1'b0; ib_wa = cc_reg; ib_wd = dval;
        db_we = 1'b0; db_wa = nd_reg; db_ra = nd_reg - BUF_AW'(1);
        cmd = '0;
        cmd.op = OP_INT;
        if (ov_reg && m_tready) ov_next = 1'b0;
        case (st_reg)
            ST_IN: begin
                if (s_tvalid && s_tready) begin
                    if (cc_reg >= 4'(MAX_CHARS)) err_next = 1'b1;
                    else begin
                        ib_we = 1'b1;
                        if (isdot) begin
                            if (dc_reg == 2'd0) dp_next = cc_reg;
                            if (dc_reg < 2'd3) dc_next = dc_reg + 2'd1;
                        end else if (!isdig) err_next = 1'b1;
                    end
                    if (cc_reg < 4'd15) cc_next = cc_reg + 4'd1;
                    if (s_last) begin
                        st_next = ST_CHECK; ix_next = '0;
                    end
                end
            end
            ST_CHECK: begin
                if (ix_reg == cc_reg || bad_chk) begin
                    if (bad_chk) begin
                        if (out_free) begin
                            ov_next = 1'b1; mc_next = '0; mb_next = 1'b1; ml_next = 1'b1;
                            st_next = ST_IN;
                            cc_next = '0; dc_next = '0; dp_next = '0; err_next = 1'b0;
                            cmd.clear = 1'b1;
                        end
                    end else begin
                        st_next = ST_ACC; ix_next = '0;
                    end
                end else begin
                    if (!(dc_reg == 2'd1 && ix_reg == dp_reg) &&
                        {1'b0, ib_rd} >= src_base) err_next = 1'b1;
                    ix_next = ix_reg + 4'd1;
                end
            end
            ST_ACC: begin
                if (ix_reg == cc_reg) begin
                    st_next = ST_IDIV; nd_next = '0;
                end else begin
                    if (!(dc_reg == 2'd1 && ix_reg == dp_reg)) begin
                        cmd.start = 1'b1;
                        cmd.digit = ib_rd;
                        cmd.op = (dc_reg == 2'd1 && ix_reg > dp_reg) ? OP_FRAC : OP_INT;
                    end
                    ix_next = ix_reg + 4'd1;
                end
            end
            ST_IDIV: begin
                cmd.start = 1'b1; cmd.op = OP_IDIV; st_next = ST_IWAIT;
            end
            ST_IWAIT: begin
                // entry being written is forwarded into db_rd_reg
                db_ra = nd_reg;
                if (!sts.busy) begin
                    db_we = 1'b1;
                    nd_next = nd_reg + BUF_AW'(1);
                    if (sts.int_zero || nd_reg == BUF_AW'(BUF_DEPTH - 1)) st_next = ST_IOUT;
                    else st_next = ST_IDIV;
                end
            end
            ST_IOUT: begin
                // db_rd_reg holds entry nd-1, fetched in the previous cycle
                if (out_free && nd_reg != '0) begin
                    ov_next = 1'b1; mc_next = to_ascii(db_rd_reg); mb_next = 1'b0;
                    ml_next = (nd_reg == BUF_AW'(1)) && !(dc_reg == 2'd1 && !sts.den_zero);
                    nd_next = nd_reg - BUF_AW'(1);
                    db_ra = nd_reg - BUF_AW'(2);
                    if (nd_reg == BUF_AW'(1)) begin
                        if (dc_reg == 2'd1 && !sts.den_zero) st_next = ST_DOT;
                        else begin
                            st_next = ST_IN; cmd.clear = 1'b1;
                            cc_next = '0; dc_next = '0; dp_next = '0; err_next = 1'b0;
                        end
                    end
                end
            end
            ST_DOT: begin
                if (out_free) begin
                    ov_next = 1'b1; mc_next = CH_DOT; mb_next = 1'b0; ml_next = 1'b0;
                    st_next = ST_FDIV; fc_next = '0;
                end
            end
            ST_FDIV: begin
                cmd.start = 1'b1; cmd.op = OP_FDIV; st_next = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (!sts.busy && out_free) begin
                    ov_next = 1'b1; mc_next = to_ascii(sts.quot); mb_next = 1'b0;
                    fc_next = fc_reg + 5'd1;
                    if (sts.rem_zero || fc_reg + 5'd1 >= 5'(MAX_FRAC_DIGITS)) begin
                        ml_next = 1'b1; st_next = ST_IN; cmd.clear = 1'b1;
                        cc_next = '0; dc_next = '0; dp_next = '0; err_next = 1'b0;
                    end else begin
                        ml_next = 1'b0; st_next = ST_FDIV;
                    end
                end
            end
            default: st_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ib_we) ibuf[ib_wa] <= ib_wd;
        if (db_we) dbuf[db_wa] <= sts.quot;
        db_rd_reg <= (db_we && db_wa == db_ra) ? sts.quot : dbuf[db_ra];
    end

    always_ff @(posedge aclk) begin
        mc_reg <= mc_next; mb_reg <= mb_next; ml_reg <= ml_next;
        ix_reg <= ix_next; nd_reg <= nd_next; fc_reg <= fc_next; dp_reg <= dp_next;
        if (!aresetn) begin
            st_reg <= ST_IN; cc_reg <= '0; dc_reg <= '0; err_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next; cc_reg <= cc_next; dc_reg <= dc_next;
            err_reg <= err_next; ov_reg <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_char   = mc_reg;
    assign m_bad    = mb_reg;
    assign m_last   = ml_reg;

    `RFC_ASSERT_IMP(a_bad_zero, aclk, aresetn, m_tvalid && m_bad, m_char == 8'd0 && m_last)
    `RFC_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, st_reg == ST_IN)
    `RFC_ASSERT_NEXT(a_start_busy, aclk, aresetn,
        cmd.start && (cmd.op == OP_IDIV || cmd.op == OP_FDIV), sts.busy)
endmodule

// ----- design/radix_fraction_converter_top.sv -----
// After the last character the input is checked and accumulated, then each
// integer digit is divided out and emitted, then the point and fraction digits.
// Synchronous active-low reset; bases reset to 10 and 2.
// Throughput: one character per cycle until last while the output is free;
// the bit-serial divider sets the output rate; no input is taken until done.
module radix_fraction_converter_top #(
    parameter int unsigned MAX_CHARS       = 12,
    parameter int unsigned MAX_FRAC_DIGITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic        m_tuser,   // bad_input
    output logic        m_tlast    // out_last
);
    import rfc_pkg::*;

    logic [BASE_W-1:0] src_reg, dst_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= 5'd10; dst_reg <= 5'd2;
        end else if (cfg_we) begin
            if (cfg_index == REG_SRC) src_reg <= cfg_data;
            if (cfg_index == REG_DST) dst_reg <= cfg_data;
        end
    end

    rfc_ctrl #(.MAX_CHARS(MAX_CHARS), .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_ctrl (
        .aclk, .aresetn, .src_base(src_reg), .dst_base(dst_reg),
        .s_tvalid, .s_tready, .s_char(s_tdata), .s_last(s_tlast),
        .m_tvalid, .m_tready, .m_char(m_tdata), .m_bad(m_tuser), .m_last(m_tlast),
        .cmd, .sts
    );

    rfc_datapath u_dp (
        .aclk, .aresetn, .src_base(src_reg), .dst_base(dst_reg), .cmd, .sts
    );
endmodule
